### hw/rtl/ssp_pkg.sv
// Shared types and constants for the servo status packet parser.
// Used by ssp_decode and servo_status_packet_parser; no dependencies.
package ssp_pkg;

	localparam int unsigned MAX_PACKET_LEN = 20;
	// Only the first eight payload bytes are ever decoded
	localparam int unsigned STORE_BYTES    = 8;
	localparam int unsigned IDX_W          = $clog2(STORE_BYTES);

	localparam logic [7:0] PREAMBLE      = 8'hFF;
	localparam logic [7:0] POS_REPLY_LEN = 8'd10;
	localparam logic [7:0] HDR_LEN       = 8'd2;

	typedef logic [1:0]  outcome_t;
	typedef logic [3:0]  kind_t;
	typedef logic [3:0]  slot_t;
	typedef logic [31:0] word_t;
	typedef logic [STORE_BYTES-1:0][7:0] store_t;

	localparam outcome_t OUT_GOOD     = 2'd0;
	localparam outcome_t OUT_CSUM_BAD = 2'd1;
	localparam outcome_t OUT_TOO_LONG = 2'd2;
	localparam outcome_t OUT_PRE2_BAD = 2'd3;

	localparam kind_t KIND_PING   = 4'd0;
	localparam kind_t KIND_STEP_A = 4'd1;
	localparam kind_t KIND_STEP_B = 4'd2;
	localparam kind_t KIND_ACCEL  = 4'd3;
	localparam kind_t KIND_SERVO0 = 4'd4;
	localparam kind_t KIND_SERVO1 = 4'd5;
	localparam kind_t KIND_SERVO2 = 4'd6;
	localparam kind_t KIND_SERVO3 = 4'd7;
	localparam kind_t KIND_ELBOW  = 4'd8;
	localparam kind_t KIND_ENC0   = 4'd9;
	localparam kind_t KIND_ENC1   = 4'd10;

	localparam slot_t SLOT_STEP_A0 = 4'd0;
	localparam slot_t SLOT_STEP_A1 = 4'd1;
	localparam slot_t SLOT_STEP_B0 = 4'd2;
	localparam slot_t SLOT_STEP_B1 = 4'd3;
	localparam slot_t SLOT_ENC_S0  = 4'd8;
	localparam slot_t SLOT_ENC_A   = 4'd9;
	localparam slot_t SLOT_ENC_B   = 4'd10;
	localparam slot_t SLOT_ELBOW   = 4'd11;

	typedef struct packed {
		logic  accepted;
		logic  snapshot;
		slot_t first_slot;
		logic  first_valid;
		word_t first_value;
		slot_t second_slot;
		logic  second_valid;
		word_t second_value;
	} decode_t;

endpackage

### hw/rtl/ssp_decode.sv
// Payload decoder: maps the stored payload and reply kind to sensor slot writes.
// Depends on ssp_pkg.
module ssp_decode (
	input  ssp_pkg::kind_t   kind,
	input  logic [7:0]       packet_length,
	input  ssp_pkg::store_t  store,
	output ssp_pkg::decode_t dec
);
	import ssp_pkg::*;

	word_t w32_lo;
	word_t w32_hi;
	word_t w16_lo;
	word_t w16_hi;

	assign w32_lo = {store[3], store[2], store[1], store[0]};
	assign w32_hi = {store[7], store[6], store[5], store[4]};
	assign w16_lo = {16'h0000, store[1], store[0]};
	assign w16_hi = {16'h0000, store[3], store[2]};

	always_comb begin
		dec = '0;
		case (kind)
			KIND_STEP_A: begin
				if (packet_length == POS_REPLY_LEN) begin
					dec.accepted     = 1'b1;
					dec.snapshot     = 1'b1;
					dec.first_slot   = SLOT_STEP_A0;
					dec.first_valid  = 1'b1;
					dec.first_value  = w32_lo;
					dec.second_slot  = SLOT_STEP_A1;
					dec.second_valid = 1'b1;
					dec.second_value = 32'd0 - w32_hi;
				end
			end
			KIND_STEP_B: begin
				if (packet_length == POS_REPLY_LEN) begin
					dec.accepted     = 1'b1;
					dec.first_slot   = SLOT_STEP_B0;
					dec.first_valid  = 1'b1;
					dec.first_value  = w32_lo;
					dec.second_slot  = SLOT_STEP_B1;
					dec.second_valid = 1'b1;
					dec.second_value = w32_hi;
				end
			end
			KIND_ACCEL: begin
				dec.accepted = 1'b1;
			end
			KIND_SERVO0, KIND_SERVO1, KIND_SERVO2, KIND_SERVO3: begin
				// servo kinds map one to one onto position slots 4..7
				dec.accepted    = 1'b1;
				dec.first_slot  = kind;
				dec.first_valid = 1'b1;
				dec.first_value = w16_lo;
			end
			KIND_ELBOW: begin
				dec.accepted    = 1'b1;
				dec.first_slot  = SLOT_ELBOW;
				dec.first_valid = 1'b1;
				dec.first_value = w16_lo;
			end
			KIND_ENC0: begin
				dec.accepted    = 1'b1;
				dec.first_slot  = SLOT_ENC_S0;
				dec.first_valid = 1'b1;
				dec.first_value = w16_hi;
			end
			KIND_ENC1: begin
				dec.accepted     = 1'b1;
				dec.first_slot   = SLOT_ENC_A;
				dec.first_valid  = 1'b1;
				dec.first_value  = w16_lo;
				dec.second_slot  = SLOT_ENC_B;
				dec.second_valid = 1'b1;
				dec.second_value = w16_hi;
			end
			default: begin
				dec = '0;
			end
		endcase
	end

endmodule

### hw/rtl/servo_status_packet_parser.sv
// Servo bus status packet parser: byte framing, running checksum, result register.
// Depends on ssp_pkg and ssp_decode.
// A result is presented in the cycle after the byte that causes it is transferred.
// Throughput: one byte per cycle; the input stalls only while a held result is stalled.
// Parse state acts on each taken byte; checksum covers ID, length, error, data bytes.
// Reset (arst_n low, asynchronous): wait for first preamble, reply kind 0, payload zero.
module servo_status_packet_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  ssp_pkg::kind_t    cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        rx_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output ssp_pkg::outcome_t outcome,
	output logic [7:0]        device_id,
	output logic [7:0]        device_error,
	output logic              accepted,
	output logic              snapshot,
	output ssp_pkg::slot_t    first_slot,
	output logic              first_valid,
	output ssp_pkg::word_t    first_value,
	output ssp_pkg::slot_t    second_slot,
	output logic              second_valid,
	output ssp_pkg::word_t    second_value
);
	import ssp_pkg::*;

	typedef enum logic [2:0] {
		PH_PRE1,
		PH_PRE2,
		PH_ID,
		PH_LEN,
		PH_ERR,
		PH_DATA,
		PH_CSUM
	} phase_t;

	phase_t     phase_q;
	kind_t      kind_q;
	logic [7:0] id_q;
	logic [4:0] len_q;
	logic [7:0] err_q;
	logic [4:0] fill_q;
	logic [7:0] sum_q;
	store_t     store_q;

	logic       out_valid_q;
	outcome_t   outcome_q;
	logic [7:0] device_id_q;
	logic [7:0] device_error_q;
	decode_t    dec_q;

	logic       take;
	logic       emit;
	logic [4:0] fill_next;
	logic [7:0] sum_next;
	decode_t    dec;

	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q & out_stall;
	assign take      = in_valid & ~in_stall;
	assign fill_next = fill_q + 5'd1;
	assign sum_next  = sum_q + rx_byte;
	assign emit      = take && ((phase_q == PH_PRE2 && rx_byte != PREAMBLE) ||
		(phase_q == PH_LEN && rx_byte > 8'(MAX_PACKET_LEN)) || phase_q == PH_CSUM);

	ssp_decode u_decode (
		.kind          (kind_q),
		.packet_length ({3'b000, len_q}),
		.store         (store_q),
		.dec           (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_PRE1;
			kind_q         <= KIND_PING;
			id_q           <= '0;
			len_q          <= '0;
			err_q          <= '0;
			fill_q         <= '0;
			sum_q          <= '0;
			store_q        <= '0;
			out_valid_q    <= 1'b0;
			outcome_q      <= OUT_GOOD;
			device_id_q    <= '0;
			device_error_q <= '0;
			dec_q          <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				kind_q <= cfg_data;
			end
			// raise on a new result, drop the held one once it is transferred
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				case (phase_q)
					PH_PRE1: begin
						if (rx_byte == PREAMBLE) begin
							phase_q <= PH_PRE2;
						end
					end
					PH_PRE2: begin
						if (rx_byte == PREAMBLE) begin
							phase_q <= PH_ID;
						end else begin
							phase_q        <= PH_PRE1;
							outcome_q      <= OUT_PRE2_BAD;
							device_id_q    <= '0;
							device_error_q <= '0;
							dec_q          <= '0;
						end
					end
					PH_ID: begin
						id_q    <= rx_byte;
						sum_q   <= rx_byte;
						phase_q <= PH_LEN;
					end
					PH_LEN: begin
						len_q  <= rx_byte[4:0];
						fill_q <= '0;
						sum_q  <= sum_next;
						if (rx_byte > 8'(MAX_PACKET_LEN)) begin
							phase_q        <= PH_PRE1;
							outcome_q      <= OUT_TOO_LONG;
							device_id_q    <= id_q;
							device_error_q <= '0;
							dec_q          <= '0;
						end else begin
							phase_q <= PH_ERR;
						end
					end
					PH_ERR: begin
						err_q <= rx_byte;
						sum_q <= sum_next;
						if (rx_byte == 8'd0 && {3'b000, len_q} > HDR_LEN) begin
							phase_q <= PH_DATA;
						end else begin
							phase_q <= PH_CSUM;
						end
					end
					PH_DATA: begin
						if (fill_q < 5'(STORE_BYTES)) begin
							store_q[fill_q[IDX_W-1:0]] <= rx_byte;
						end
						fill_q <= fill_next;
						sum_q  <= sum_next;
						if ({3'b000, fill_next} + HDR_LEN >= {3'b000, len_q}) begin
							phase_q <= PH_CSUM;
						end
					end
					PH_CSUM: begin
						phase_q        <= PH_PRE1;
						device_id_q    <= id_q;
						device_error_q <= err_q;
						if (~sum_q != rx_byte) begin
							outcome_q <= OUT_CSUM_BAD;
							dec_q     <= '0;
						end else begin
							outcome_q <= OUT_GOOD;
							dec_q     <= dec;
						end
					end
					default: begin
						phase_q <= PH_PRE1;
					end
				endcase
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign outcome      = outcome_q;
	assign device_id    = device_id_q;
	assign device_error = device_error_q;
	assign accepted     = dec_q.accepted;
	assign snapshot     = dec_q.snapshot;
	assign first_slot   = dec_q.first_slot;
	assign first_valid  = dec_q.first_valid;
	assign first_value  = dec_q.first_value;
	assign second_slot  = dec_q.second_slot;
	assign second_valid = dec_q.second_valid;
	assign second_value = dec_q.second_value;

endmodule
